@@ sv/ksort_pkg.sv @@
package ksort_pkg;

  // Widths fixed by the item and register formats.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned K_W     = 4;

  // Default window storage depth and the distance loaded at reset.
  localparam int unsigned WINDOW_DEPTH_DEFAULT = 16;
  localparam logic [K_W-1:0] K_RESET = 4'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // input word taken this cycle
    logic scan_start;  // clear the scan pointer
    logic scan_step;   // read one window entry and advance
    logic emit;        // load the result register and move the tail entry
  } ksort_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need;        // a smallest value must leave the window
    logic scan_last;   // the pointer is at the last held entry
    logic out_free;    // the result register can take a new word
  } ksort_status_t;

endpackage

@@ sv/ksort_ram.sv @@
module ksort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ksort_ctrl.sv @@
module ksort_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ksort_pkg::ksort_status_t  status_i,
  output ksort_pkg::ksort_cmd_t     cmd_o
);

  import ksort_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.need) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // The last read word is compared in this cycle.
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

@@ sv/ksort_dp.sv @@
module ksort_dp #(
  parameter int unsigned WINDOW_DEPTH = ksort_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ksort_pkg::ksort_cmd_t           cmd_i,
  output ksort_pkg::ksort_status_t        status_o,
  input  logic [ksort_pkg::VALUE_W-1:0]   in_value_i,
  input  logic                            in_last_i,
  input  logic                            cfg_valid_i,
  input  logic [ksort_pkg::K_W-1:0]       cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ksort_pkg::VALUE_W-1:0]   out_value_o,
  output logic                            out_last_o
);

  import ksort_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned KW = (CW > K_W) ? CW : K_W;
  localparam logic [KW-1:0] K_MAX = KW'(WINDOW_DEPTH - 1);

  logic [K_W-1:0]     k_q;
  logic [CW-1:0]      count_q, count_d;
  logic               last_q;
  logic [CW-1:0]      ptr_q;
  logic               rd_valid_q;
  logic [AW-1:0]      rd_idx_q;
  logic [VALUE_W-1:0] min_q, tail_q;
  logic [AW-1:0]      best_q;
  logic               out_valid_q, out_last_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [VALUE_W-1:0] rdata;
  logic [KW-1:0]      k_ext, eff_k, count_ext;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;

  // Distance register, written only while the block is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_RESET;
    end else if (cfg_valid_i) begin
      k_q <= cfg_data_i;
    end
  end

  // Effective distance is capped so an insert always finds room.
  always_comb begin
    k_ext     = KW'(k_q);
    eff_k     = (k_ext > K_MAX) ? K_MAX : k_ext;
    count_ext = KW'(count_q);
  end

  // Window store: inserts at the fill point, the tail fills the hole on removal.
  assign ram_we    = cmd_i.accept | cmd_i.emit;
  assign ram_waddr = cmd_i.accept ? count_q[AW-1:0] : best_q;
  assign ram_wdata = cmd_i.accept ? in_value_i : tail_q;

  ksort_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan_step),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Fill count and drain flag.
  always_comb begin
    count_d = count_q;
    if (cmd_i.accept) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.emit) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.accept) begin
        last_q <= in_last_i;
      end else if (cmd_i.emit && (count_d == '0)) begin
        last_q <= 1'b0;
      end
    end
  end

  // Scan pointer and read pipeline tag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      rd_valid_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        ptr_q <= '0;
      end else if (cmd_i.scan_step) begin
        ptr_q    <= ptr_q + 1'b1;
        rd_idx_q <= ptr_q[AW-1:0];
      end
    end
  end

  // Running minimum; the last word read is the tail entry.
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      tail_q <= rdata;
      if ((rd_idx_q == '0) || ($signed(rdata) < $signed(min_q))) begin
        min_q  <= rdata;
        best_q <= rd_idx_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= min_q;
      out_last_q  <= last_q && (count_d == '0);
    end
  end

  assign status_o.need      = last_q ? (count_q != '0) : (count_ext > eff_k);
  assign status_o.scan_last = (ptr_q == (count_q - 1'b1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  // The fill count never exceeds the storage depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(WINDOW_DEPTH))
    else $error("window fill count exceeds depth");

  // A result is only loaded when the previous one has left or is leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // The final word of a drain leaves the window empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && last_q && (count_q == CW'(1))) |=> (count_q == '0) && out_last_q)
    else $error("drain did not end with an empty window");

  // No insert happens while a scan is running, and a scan never runs on an empty window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> !cmd_i.accept && (count_q != '0))
    else $error("scan overlapped an insert");

endmodule

@@ sv/k_sorted_stream_sorter.sv @@
// A word is taken in IDLE; if no result is due, the block passes through DECIDE back to IDLE.
// Each result passes through DECIDE, a scan that reads one window entry per cycle, WAIT for the
// last compare and EMIT, which waits while the result register is still full.
// A new word is not taken until every result released by the previous word has been emitted;
// a drain repeats these steps for each result until the window is empty.
// Reset: fill count and drain flag clear, distance goes to 4; window contents are undefined
// and need no clearing pass.
module k_sorted_stream_sorter #(
  parameter int unsigned WINDOW_DEPTH = ksort_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ksort_pkg::VALUE_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ksort_pkg::VALUE_W-1:0] m_axis_tdata_o,  // [31:0] value_res
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ksort_pkg::K_W-1:0]     cfg_data_i
);

  import ksort_pkg::*;

  ksort_cmd_t    cmd;
  ksort_status_t status;

  // The distance register takes a write only while no word is being processed.
  assign cfg_ready_o = s_axis_tready_o;

  ksort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ksort_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import ksort_pkg::*;

  localparam int unsigned WIN           = WINDOW_DEPTH_DEFAULT;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One result word as the block should emit it.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } sorted_word_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [VALUE_W-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [VALUE_W-1:0]  m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [K_W-1:0]      cfg_data_i      = '0;

  // Shadow copy of the window, the distance and the results still owed.
  logic signed [VALUE_W-1:0] window_vals[$];
  logic [K_W-1:0]            k_model = K_RESET;
  sorted_word_t              expected_words[$];
  sorted_word_t              oldest_word;

  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned sent_words     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  k_sorted_stream_sorter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Removes the smallest held value from the shadow window.
  function automatic logic signed [VALUE_W-1:0] pop_smallest();
    int unsigned               best;
    logic signed [VALUE_W-1:0] v;
    best = 0;
    for (int unsigned i = 1; i < window_vals.size(); i++) begin
      if (window_vals[i] < window_vals[best]) best = i;
    end
    v = window_vals[best];
    window_vals.delete(best);
    return v;
  endfunction

  // Inserts one accepted word and queues the results it releases.
  function automatic void predict_word(input logic signed [VALUE_W-1:0] value,
                                       input logic last);
    sorted_word_t res;
    int unsigned  eff_k;
    eff_k = (k_model > WIN - 1) ? WIN - 1 : k_model;
    if (window_vals.size() < WIN) window_vals.push_back(value);
    if (last) begin
      while (window_vals.size() > 0) begin
        res.value = pop_smallest();
        res.last  = (window_vals.size() == 0);
        expected_words.push_back(res);
      end
    end else begin
      while (window_vals.size() > eff_k) begin
        res.value = pop_smallest();
        res.last  = 1'b0;
        expected_words.push_back(res);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("MISMATCH cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Receiver stalls at random according to the current idle share.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata_o, '0);
      end else begin
        oldest_word = expected_words.pop_front();
        if (m_axis_tdata_o !== oldest_word.value)
          report_mismatch("value", m_axis_tdata_o, oldest_word.value);
        if (m_axis_tlast_o !== oldest_word.last)
          report_mismatch("last flag", VALUE_W'(m_axis_tlast_o), VALUE_W'(oldest_word.last));
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one word, with random gaps before it, and predicts on acceptance.
  task automatic send_word(input logic signed [VALUE_W-1:0] value, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_word(value, last);
    sent_words++;
  endtask

  // Holds the input off until every predicted word has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the distance register once the block is quiet.
  task automatic write_k(input logic [K_W-1:0] k);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    k_model = k;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends a run of words; a well-formed run is sorted and then shuffled within
  // blocks of k+1, so no word sits more than k places from its sorted spot.
  task automatic send_stream(input int unsigned len, input bit well_formed, input bit close);
    logic signed [VALUE_W-1:0] vals[$];
    logic signed [VALUE_W-1:0] tmp;
    int unsigned               span;
    int unsigned               top;
    int unsigned               r;
    bit                        narrow;
    narrow = ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      vals.push_back(narrow ? $signed($urandom_range(16)) - 32'sd8 : $signed($urandom));
    end
    if (well_formed) begin
      vals.sort();
      span = k_model + 1;
      for (int unsigned base = 0; base < len; base += span) begin
        top = (base + span < len) ? base + span : len;
        for (int unsigned j = top - 1; j > base; j--) begin
          r       = $urandom_range(j, base);
          tmp     = vals[j];
          vals[j] = vals[r];
          vals[r] = tmp;
        end
      end
    end
    for (int unsigned i = 0; i < len; i++) begin
      send_word(vals[i], close && (i == len - 1));
    end
  endtask

  // The reset distance of four, with the corners of the signed range.
  task automatic test_value_extremes();
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh0000_0000, 1'b0);
    send_word(32'shFFFF_FFFF, 1'b0);
    send_word(32'sh0000_0001, 1'b0);
    send_word(32'sh8000_0001, 1'b0);
    send_word(32'sh7FFF_FFFE, 1'b0);
    send_word(32'sh5555_AAAA, 1'b1);
  endtask

  // A marked word into an empty window comes straight back as the final word.
  task automatic test_lone_last();
    send_word(32'shA5A5_5A5A, 1'b1);
  endtask

  // Equal values leave together; their order does not change the output.
  task automatic test_equal_values();
    send_word(32'sh1234_5678, 1'b0);
    send_word(32'shFFFF_FFFF, 1'b0);
    send_word(32'sh1234_5678, 1'b0);
    send_word(32'shFFFF_FFFF, 1'b0);
    send_word(32'sh1234_5678, 1'b0);
    send_word(32'shFFFF_FFFF, 1'b1);
  endtask

  // Lowering k while values are held releases several words on the next input.
  task automatic test_distance_lowered();
    write_k(4'd4);
    send_word(32'sd40, 1'b0);
    send_word(-32'sd7, 1'b0);
    send_word(32'sd19, 1'b0);
    send_word(32'sd3, 1'b0);
    write_k(4'd1);
    send_word(32'sd11, 1'b0);
    send_word(-32'sd2, 1'b1);
  endtask

  // With a distance of zero each word passes straight through.
  task automatic test_zero_distance();
    write_k(4'd0);
    send_word(32'sh0F0F_F0F0, 1'b0);
    send_word(32'shF0F0_0F0F, 1'b1);
  endtask

  // Mostly k-sorted runs with random content, some noise and unterminated runs,
  // k changes between runs and occasional hold-offs until the output is empty.
  task automatic test_random_traffic(input int unsigned items, input int unsigned tx_pct,
                                     input int unsigned rx_pct, input logic [K_W-1:0] first_k);
    int unsigned stop;
    int unsigned roll;
    int unsigned pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_k(first_k);
    stop = sent_words + items;
    while (sent_words < stop) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        pick = $urandom_range(3);
        write_k((pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom_range(15)));
      end else if (roll >= 90) begin
        wait_drained();
      end
      send_stream($urandom_range(2 * k_model + 4, 1), $urandom_range(99) >= 15,
                  $urandom_range(99) >= 10);
    end
    send_word($urandom, 1'b1);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 27;
    rx_idle_pct = 87;
    test_value_extremes();
    test_lone_last();
    test_equal_values();
    test_distance_lowered();
    test_zero_distance();

    test_random_traffic(100, 27, 87, 4'd15);
    test_random_traffic(100, 87, 27, 4'd0);
    test_random_traffic(100, 0, 0, 4'd15);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
